>>> src/smv_pkg.sv
// ----------------------------------------------------------------------------
// Servo move tracker package
// Widths, constants and command codes shared by the servo move tracker.
// ----------------------------------------------------------------------------
package smv_pkg;

    // Fixed-point format of angles and width of the elapsed-tick counter.
    localparam int FRAC_BITS  = 10;
    localparam int TICK_BITS  = 20;

    // Field widths.
    localparam int MODE_W     = 3;
    localparam int POS_W      = 19;
    localparam int SPEED_W    = 16;
    localparam int CMP_W      = 7;
    localparam int ANGLE_W    = FRAC_BITS + 8;            // holds 180 degrees
    localparam int MOVE_W     = ANGLE_W + 1;              // signed move
    localparam int CALC_W     = MOVE_W + 1;               // signed estimate math
    localparam int POSC_W     = (POS_W > MOVE_W) ? POS_W : MOVE_W;
    localparam int TRAVEL_W   = TICK_BITS + SPEED_W;

    // Angle and counter limits.
    localparam logic [ANGLE_W-1:0]   FULL_ANGLE  = ANGLE_W'(180) << FRAC_BITS;
    localparam logic [TICK_BITS-1:0] TICK_MAX    = '1;
    localparam logic [SPEED_W-1:0]   SPEED_RESET = SPEED_W'(600);

    // Compare value = target * 100 / (180 << FRAC_BITS) + 25.
    // The ratio 100/180 is 5/9: first x = (5 * target) >> FRAC_BITS, which
    // stays at or below 900, then x / 9 as (x * 911) >> 13, exact below 1170.
    localparam int               SCALED_W   = ANGLE_W + 3;
    localparam int               X_W        = SCALED_W - FRAC_BITS;
    localparam int               RECIP_W    = 10;
    localparam logic [RECIP_W-1:0] DIV9_RECIP = RECIP_W'(911);
    localparam int               DIV9_SHIFT = 13;
    localparam logic [CMP_W-1:0] CMP_OFFSET = CMP_W'(25);

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK   = 3'd0,
        MODE_SET    = 3'd1,
        MODE_FORCE  = 3'd2,
        MODE_STOP   = 3'd3,
        MODE_INIT   = 3'd4
    } mode_t;

endpackage

>>> src/servo_move_tracker.sv
// ----------------------------------------------------------------------------
// Servo move tracker
// Tracks hobby servo commands: target, PWM compare, move completion and an
// interpolated position estimate, one result item per input item.
// ----------------------------------------------------------------------------
// Output: the result item for an input item is held in the result register and
// appears in the cycle after the input item is accepted.
// Throughput: one item per cycle while the output does not stall; the critical
// path is the tick-by-speed multiplier followed by the completion compare and the estimate adder.
// Reset: target 0, move 0, elapsed counter saturated, output stopped, speed 600,
// result register empty.
module servo_move_tracker
    import smv_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_we,
    input  logic [SPEED_W-1:0]         cfg_data,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [MODE_W-1:0]          mode,
    input  logic signed [POS_W-1:0]    position,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [CMP_W-1:0]           compare_value,
    output logic                       accepted,
    output logic                       available,
    output logic [ANGLE_W-1:0]         estimated_position
);

    // ------------------------------------------------------------------------
    // State registers. The move speed is the only configuration register.
    // ------------------------------------------------------------------------
    logic [SPEED_W-1:0]        speed_reg;
    logic [ANGLE_W-1:0]        target_reg,  target_next;
    logic signed [MOVE_W-1:0]  move_reg,    move_next;
    logic [TICK_BITS-1:0]      elapsed_reg, elapsed_next;
    logic                      enabled_reg, enabled_next;

    // Result register.
    logic                      out_valid_reg;
    logic [CMP_W-1:0]          compare_reg,   compare_next;
    logic                      accepted_reg,  accepted_next;
    logic                      available_reg, available_next;
    logic [ANGLE_W-1:0]        estimate_reg,  estimate_next;

    logic                      accept;

    // Working signals of the combinational update.
    logic [TRAVEL_W-1:0]       travel_cur;
    logic [TRAVEL_W-1:0]       travel_new;
    logic [ANGLE_W-1:0]        mag_cur;
    logic [ANGLE_W-1:0]        mag_new;
    logic                      avail_cur;
    logic signed [POSC_W-1:0]  pos_wide;
    logic [ANGLE_W-1:0]        pos_clamped;
    logic signed [CALC_W-1:0]  prev_target;
    logic signed [CALC_W-1:0]  travel_short;
    logic signed [CALC_W-1:0]  estimate_wide;
    logic [SCALED_W-1:0]       scaled;
    logic [X_W+RECIP_W-1:0]    quot_prod;

    // The result register is one deep: a new item is taken whenever it is
    // empty or its item leaves in the same cycle.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // The travel since the last set is elapsed ticks times speed. Only the
    // current travel is multiplied; the travel after the item follows from it
    // with at most one add, because a tick adds exactly one speed step, a set
    // restarts at zero and init saturates the counter.
    assign travel_cur = TRAVEL_W'(elapsed_reg) * TRAVEL_W'(speed_reg);
    assign mag_cur    = move_reg[MOVE_W-1] ? ANGLE_W'(-move_reg) : ANGLE_W'(move_reg);
    assign avail_cur  = travel_cur > TRAVEL_W'(mag_cur);

    // Clamp the requested angle to the usable range of zero to 180 degrees.
    assign pos_wide = POSC_W'(position);

    always_comb
    begin
        if (pos_wide < 0)
        begin
            pos_clamped = '0;
        end
        else if (pos_wide > $signed(POSC_W'(FULL_ANGLE)))
        begin
            pos_clamped = FULL_ANGLE;
        end
        else
        begin
            pos_clamped = ANGLE_W'(pos_wide);
        end
    end

    // Next state and the result item.
    always_comb
    begin
        target_next   = target_reg;
        move_next     = move_reg;
        elapsed_next  = elapsed_reg;
        enabled_next  = enabled_reg;
        travel_new    = travel_cur;
        accepted_next = 1'b0;

        case (mode_t'(mode))
            MODE_TICK:
            begin
                if (elapsed_reg != TICK_MAX)
                begin
                    elapsed_next = elapsed_reg + 1'b1;
                    travel_new   = travel_cur + TRAVEL_W'(speed_reg);
                end
            end
            MODE_SET, MODE_FORCE:
            begin
                // A plain set applies only once the last move is judged complete; else it is refused.
                if (mode_t'(mode) == MODE_FORCE || avail_cur)
                begin
                    target_next   = pos_clamped;
                    move_next     = MOVE_W'($signed({1'b0, pos_clamped}))
                                  - MOVE_W'($signed({1'b0, target_reg}));
                    elapsed_next  = '0;
                    travel_new    = '0;
                    accepted_next = 1'b1;
                end
            end
            MODE_STOP:
            begin
                enabled_next = 1'b0;
            end
            MODE_INIT:
            begin
                target_next   = pos_clamped;
                move_next     = '0;
                elapsed_next  = TICK_MAX;
                travel_new    = (TRAVEL_W'(speed_reg) << TICK_BITS) - TRAVEL_W'(speed_reg);
                enabled_next  = 1'b1;
                accepted_next = 1'b1;
            end
            default:
            begin
                // Unused codes leave everything alone, time included.
            end
        endcase

        mag_new        = move_next[MOVE_W-1] ? ANGLE_W'(-move_next) : ANGLE_W'(move_next);
        available_next = travel_new > TRAVEL_W'(mag_new);

        // While the move is not complete the travel is at most the move's
        // size, so it fits the angle width and the estimate stays in range.
        prev_target   = CALC_W'($signed({1'b0, target_next})) - CALC_W'(move_next);
        travel_short  = CALC_W'($signed({1'b0, travel_new[ANGLE_W-1:0]}));
        if (move_next > 0)
        begin
            estimate_wide = prev_target + travel_short;
        end
        else
        begin
            estimate_wide = prev_target - travel_short;
        end
        estimate_next = available_next ? target_next : ANGLE_W'(estimate_wide);

        // PWM compare from the new target, or zero while the output is stopped.
        scaled    = {target_next, 2'b00} + SCALED_W'(target_next);
        quot_prod = (X_W+RECIP_W)'(scaled[SCALED_W-1:FRAC_BITS]) * (X_W+RECIP_W)'(DIV9_RECIP);
        if (enabled_next)
        begin
            compare_next = quot_prod[DIV9_SHIFT +: CMP_W] + CMP_OFFSET;
        end
        else
        begin
            compare_next = '0;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= SPEED_RESET;
            target_reg    <= '0;
            move_reg      <= '0;
            elapsed_reg   <= TICK_MAX;
            enabled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                speed_reg <= cfg_data;
            end
            if (accept)
            begin
                target_reg    <= target_next;
                move_reg      <= move_next;
                elapsed_reg   <= elapsed_next;
                enabled_reg   <= enabled_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; it loads only with a new item, so it holds while stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            compare_reg   <= compare_next;
            accepted_reg  <= accepted_next;
            available_reg <= available_next;
            estimate_reg  <= estimate_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign compare_value      = compare_reg;
    assign accepted           = accepted_reg;
    assign available          = available_reg;
    assign estimated_position = estimate_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // The target never leaves the usable range.
    assert property (@(posedge clk) disable iff (!rst_n)
        target_reg <= FULL_ANGLE)
        else $error("target angle beyond 180 degrees");

    // A tick advances an unsaturated counter by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_TICK && elapsed_reg != TICK_MAX)
        |=> elapsed_reg == $past(elapsed_reg) + 1'b1)
        else $error("tick did not advance the elapsed counter");

    // A forced set is always taken and restarts the counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_FORCE) |=> (accepted_reg && elapsed_reg == '0))
        else $error("forced set not applied");

    // A stop item reports a zero compare value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_STOP) |=> (compare_reg == '0 && !accepted_reg))
        else $error("stop item left the output running");

    // A completed move reports the target itself as the estimate.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && available_reg) |-> estimate_reg == target_reg)
        else $error("estimate differs from target after a completed move");

endmodule
